[sv/gmbs_pkg.sv]
// shared constants, types and state encoding for the grid mask brush stamp unit
package gmbs_pkg;

	localparam int MAX_SIDE    = 64;
	localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int WORD_W      = 64;
	localparam int WORD_DEPTH  = STORE_DEPTH / WORD_W;
	localparam int WADDR_W     = $clog2(WORD_DEPTH);
	localparam int POS_W       = $clog2(WORD_W);
	localparam int SIDE_W      = 7;
	localparam int IDX_W       = 12;
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int COORD_W     = 24;
	localparam int RAD_W       = 23;
	localparam int SPACE_W     = 16;
	localparam int POS2_W      = COORD_W + 3;
	localparam int MAG_W       = POS2_W - 1;
	localparam int SQ_W        = 2 * MAG_W;
	localparam int D2_W        = SQ_W + 1;
	localparam int TH_W        = 2 * RAD_W + 2;
	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 32;
	localparam int REG_W       = 2;

	localparam logic [SIDE_W-1:0]  RST_SIDE    = SIDE_W'(MAX_SIDE);
	localparam logic [SPACE_W-1:0] RST_SPACING = SPACE_W'(256);

	typedef enum logic [1:0] {
		CMD_STROKE = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		FO_CONST  = 2'd0,
		FO_LINEAR = 2'd1,
		FO_SMOOTH = 2'd2,
		FO_SHARP  = 2'd3
	} falloff_t;

	typedef enum logic [REG_W-1:0] {
		REG_SIDE     = 2'd0,
		REG_ORIGIN_X = 2'd1,
		REG_ORIGIN_Z = 2'd2,
		REG_SPACING  = 2'd3
	} reg_t;

	typedef struct packed {
		logic [SIDE_W-1:0]         side;
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_z;
		logic [SPACE_W-1:0]        spacing;
	} cfg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RSQ,
		S_RSQ_W,
		S_RSQ_T,
		S_ROW,
		S_ROW_W,
		S_ROW_T,
		S_RD,
		S_LOAD,
		S_RUN,
		S_DRAIN,
		S_WR,
		S_DONE
	} state_t;

endpackage

[sv/gmbs_if.sv]
// command and result channel interfaces
interface gmbs_in_if;
	import gmbs_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [1:0]                command;
	logic [IDX_W-1:0]          quad_index;
	logic                      quad_value;
	logic signed [COORD_W-1:0] brush_x;
	logic signed [COORD_W-1:0] brush_z;
	logic [RAD_W-1:0]          brush_radius;
	logic                      brush_shape;
	logic [1:0]                brush_falloff;
	logic                      erase;

	modport source (
		output valid, command, quad_index, quad_value, brush_x, brush_z,
		       brush_radius, brush_shape, brush_falloff, erase,
		input  ready
	);
	modport sink (
		input  valid, command, quad_index, quad_value, brush_x, brush_z,
		       brush_radius, brush_shape, brush_falloff, erase,
		output ready
	);
endinterface

interface gmbs_out_if;
	logic valid;
	logic ready;
	logic modified;
	logic read_value;

	modport source (output valid, modified, read_value, input ready);
	modport sink (input valid, modified, read_value, output ready);
endinterface

[sv/gmbs_ram.sv]
// generic single write port ram with registered read
module gmbs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

[sv/gmbs_cfg.sv]
// apb configuration registers
module gmbs_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gmbs_pkg::PADDR_W-1:0]  paddr,
	input  logic [gmbs_pkg::PDATA_W-1:0]  pwdata,
	output logic [gmbs_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output gmbs_pkg::cfg_t                cfg
);
	import gmbs_pkg::*;

	cfg_t cfg_q;
	reg_t sel;
	logic wr;

	assign sel    = reg_t'(paddr[PADDR_W-1:PADDR_W-REG_W]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.side     <= RST_SIDE;
			cfg_q.origin_x <= '0;
			cfg_q.origin_z <= '0;
			cfg_q.spacing  <= RST_SPACING;
		end else if (wr) begin
			case (sel)
				REG_SIDE:     cfg_q.side     <= pwdata[SIDE_W-1:0];
				REG_ORIGIN_X: cfg_q.origin_x <= pwdata[COORD_W-1:0];
				REG_ORIGIN_Z: cfg_q.origin_z <= pwdata[COORD_W-1:0];
				REG_SPACING:  cfg_q.spacing  <= pwdata[SPACE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_SIDE:     prdata = {{(PDATA_W-SIDE_W){1'b0}}, cfg_q.side};
			REG_ORIGIN_X: prdata = {{(PDATA_W-COORD_W){1'b0}}, cfg_q.origin_x};
			REG_ORIGIN_Z: prdata = {{(PDATA_W-COORD_W){1'b0}}, cfg_q.origin_z};
			REG_SPACING:  prdata = {{(PDATA_W-SPACE_W){1'b0}}, cfg_q.spacing};
			default:      prdata = '0;
		endcase
	end
endmodule

[sv/gmbs_sq_unit.sv]
// shared two stage squarer for radius, row and quad distances
module gmbs_sq_unit (
	input  logic                        clk,
	input  logic [gmbs_pkg::MAG_W-1:0]  op,
	output logic [gmbs_pkg::SQ_W-1:0]   sq
);
	import gmbs_pkg::*;

	logic [MAG_W-1:0] op_s1;
	logic [SQ_W-1:0]  sq_s2;

	always_ff @(posedge clk) begin
		op_s1 <= op;
		sq_s2 <= op_s1 * op_s1;
	end

	assign sq = sq_s2;
endmodule

[sv/grid_mask_brush_stamp_unit.sv]
// top level: command sequencer, quad walk and hole mask store
// A one-bit hole mask over a square grid of quads, held as 64-bit words
// in a ram with one valid flop per word, so reset clears it at once.
// in_ch takes commands: stroke, write one quad, read one quad.
// out_ch returns one item per command (modified, read_value).
// Configuration goes through the apb port; the user must write it only
// while the block is idle; it does not enforce this. in_ch.ready is
// high only while idle; each command is worked alone. A read goes
// through read and load, a write through read, load and write back;
// unknown or out-of-range commands and a zero radius or side go
// straight to done. A stroke walks quads in index order through one
// shared squarer, one quad per cycle in the run state; each 64-quad
// word adds read, load, drain, write back; each row its distance square.
// A finished item sits in the output register until out_ch.ready;
// the next command is taken meanwhile, but its result waits for that
// register to empty.
module grid_mask_brush_stamp_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	gmbs_in_if.sink                       in_ch,
	gmbs_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gmbs_pkg::PADDR_W-1:0]  paddr,
	input  logic [gmbs_pkg::PDATA_W-1:0]  pwdata,
	output logic [gmbs_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import gmbs_pkg::*;

	cfg_t   cfg;
	state_t state_q, state_d;

	logic                      stroke_q, rdcmd_q, shape_q, erase_q, strict_q;
	logic [1:0]                falloff_q;
	logic [RAD_W-1:0]          r_q;
	logic signed [POS2_W-1:0]  bx2_q, bz2_q, cx2_q, cz2_q;
	logic [SIDE_W-1:0]         n_q, x_q, z_q;
	logic [CNT_W-1:0]          nn_q, idx_q;
	logic [MAG_W-1:0]          az_q;
	logic [SQ_W-1:0]           az2_q;
	logic [TH_W-1:0]           th_q;
	logic [WORD_W-1:0]         old_q, hit_q;
	logic [WADDR_W-1:0]        waddr_q;
	logic [WORD_DEPTH-1:0]     row_valid_q;
	logic                      rdv_q, changed_q, rbit_q, word_open_q;
	logic                      end_all_q, end_word_q, end_row_q;
	logic                      v_s1, v_s2;
	logic [POS_W-1:0]          pos_s1, pos_s2;
	logic                      out_valid_q, out_mod_q, out_read_q;

	logic                      accept, load_out, issue_last, row_last, word_last;
	logic [SIDE_W-1:0]         side_sat;
	logic [CNT_W-1:0]          nn_in;
	logic signed [POS2_W-1:0]  cx_init, cz_init, step2, dx, dz, ndx, ndz;
	logic [MAG_W-1:0]          ax, az_now, mx, sq_op;
	logic [SQ_W-1:0]           sq;
	logic [D2_W-1:0]           d2, th_ext;
	logic                      hit_now;
	logic [WADDR_W-1:0]        raddr;
	logic [WORD_W-1:0]         rdata, word_eff, new_word;
	logic                      ram_we;

	gmbs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gmbs_sq_unit u_sq (
		.clk (clk),
		.op  (sq_op),
		.sq  (sq)
	);

	gmbs_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WORD_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr_q),
		.wdata (new_word),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign in_ch.ready       = (state_q == S_IDLE);
	assign accept            = in_ch.valid & in_ch.ready;
	assign out_ch.valid      = out_valid_q;
	assign out_ch.modified   = out_mod_q;
	assign out_ch.read_value = out_read_q;

	assign side_sat = (cfg.side > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : cfg.side;
	assign nn_in    = CNT_W'(side_sat) * CNT_W'(side_sat);

	assign step2   = {{(POS2_W-SPACE_W-1){1'b0}}, cfg.spacing, 1'b0};
	assign cx_init = {{(POS2_W-COORD_W-1){cfg.origin_x[COORD_W-1]}}, cfg.origin_x, 1'b0}
	               + {{(POS2_W-SPACE_W){1'b0}}, cfg.spacing};
	assign cz_init = {{(POS2_W-COORD_W-1){cfg.origin_z[COORD_W-1]}}, cfg.origin_z, 1'b0}
	               + {{(POS2_W-SPACE_W){1'b0}}, cfg.spacing};

	assign dx     = cx2_q - bx2_q;
	assign dz     = cz2_q - bz2_q;
	assign ndx    = -dx;
	assign ndz    = -dz;
	assign ax     = dx[POS2_W-1] ? ndx[MAG_W-1:0] : dx[MAG_W-1:0];
	assign az_now = dz[POS2_W-1] ? ndz[MAG_W-1:0] : dz[MAG_W-1:0];
	assign mx     = (ax > az_q) ? ax : az_q;

	always_comb begin
		case (state_q)
			S_RSQ:   sq_op = MAG_W'(r_q);
			S_ROW:   sq_op = az_now;
			S_RUN:   sq_op = shape_q ? mx : ax;
			default: sq_op = '0;
		endcase
	end

	assign d2      = shape_q ? D2_W'(sq) : D2_W'(sq) + D2_W'(az2_q);
	assign th_ext  = D2_W'(th_q);
	assign hit_now = strict_q ? (d2 < th_ext) : (d2 <= th_ext);

	assign row_last   = (x_q == n_q - SIDE_W'(1));
	assign word_last  = (idx_q[POS_W-1:0] == {POS_W{1'b1}});
	assign issue_last = row_last | word_last;

	assign raddr    = idx_q[IDX_W-1:POS_W];
	assign word_eff = rdv_q ? rdata : '0;
	assign new_word = erase_q ? (old_q & ~hit_q) : (old_q | hit_q);
	assign ram_we   = (state_q == S_WR);
	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_ch.command == CMD_STROKE) begin
						if (in_ch.brush_radius == '0 || side_sat == '0) begin
							state_d = S_DONE;
						end else begin
							state_d = S_RSQ;
						end
					end else if ((in_ch.command == CMD_WRITE || in_ch.command == CMD_READ)
					             && (CNT_W'(in_ch.quad_index) < nn_in)) begin
						state_d = S_RD;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_RSQ:   state_d = S_RSQ_W;
			S_RSQ_W: state_d = S_RSQ_T;
			S_RSQ_T: state_d = S_ROW;
			S_ROW:   state_d = S_ROW_W;
			S_ROW_W: state_d = S_ROW_T;
			S_ROW_T: state_d = word_open_q ? S_RUN : S_RD;
			S_RD:    state_d = S_LOAD;
			S_LOAD: begin
				if (stroke_q) begin
					state_d = S_RUN;
				end else if (rdcmd_q) begin
					state_d = S_DONE;
				end else begin
					state_d = S_WR;
				end
			end
			S_RUN: begin
				if (issue_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = (end_word_q || end_all_q) ? S_WR : S_ROW;
				end
			end
			S_WR: begin
				if (!stroke_q || end_all_q) begin
					state_d = S_DONE;
				end else if (end_row_q) begin
					state_d = S_ROW;
				end else begin
					state_d = S_RD;
				end
			end
			S_DONE: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			row_valid_q <= '0;
			word_open_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == S_RUN);
			v_s2    <= v_s1;
			if (ram_we) begin
				row_valid_q[waddr_q] <= 1'b1;
			end
			if (accept || ram_we) begin
				word_open_q <= 1'b0;
			end else if (state_q == S_LOAD) begin
				word_open_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= idx_q[POS_W-1:0];
		pos_s2 <= pos_s1;
		if (load_out) begin
			out_mod_q  <= changed_q;
			out_read_q <= rbit_q;
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					stroke_q  <= (in_ch.command == CMD_STROKE);
					rdcmd_q   <= (in_ch.command == CMD_READ);
					shape_q   <= in_ch.brush_shape;
					falloff_q <= in_ch.brush_falloff;
					erase_q   <= (in_ch.command == CMD_WRITE) ? ~in_ch.quad_value : in_ch.erase;
					r_q       <= in_ch.brush_radius;
					bx2_q     <= {{(POS2_W-COORD_W-1){in_ch.brush_x[COORD_W-1]}},
					              in_ch.brush_x, 1'b0};
					bz2_q     <= {{(POS2_W-COORD_W-1){in_ch.brush_z[COORD_W-1]}},
					              in_ch.brush_z, 1'b0};
					n_q       <= side_sat;
					nn_q      <= nn_in;
					idx_q     <= (in_ch.command == CMD_STROKE) ? '0 : CNT_W'(in_ch.quad_index);
					x_q       <= '0;
					z_q       <= '0;
					cx2_q     <= cx_init;
					cz2_q     <= cz_init;
					changed_q <= 1'b0;
					rbit_q    <= 1'b0;
				end
			end
			S_RSQ_T: begin
				strict_q <= (falloff_q == FO_CONST);
				case (falloff_q)
					FO_CONST:  th_q <= {sq[TH_W-3:0], 2'b00};
					FO_LINEAR: th_q <= {2'b00, sq[TH_W-3:0]};
					FO_SMOOTH: th_q <= {2'b00, sq[TH_W-3:0]};
					FO_SHARP:  th_q <= {1'b0, sq[TH_W-3:0], 1'b0};
					default:   th_q <= {2'b00, sq[TH_W-3:0]};
				endcase
			end
			S_ROW:   az_q  <= az_now;
			S_ROW_T: az2_q <= sq;
			S_RD: begin
				waddr_q <= raddr;
				rdv_q   <= row_valid_q[raddr];
			end
			S_LOAD: begin
				old_q  <= word_eff;
				hit_q  <= stroke_q ? '0 : ({{(WORD_W-1){1'b0}}, 1'b1} << idx_q[POS_W-1:0]);
				rbit_q <= rdcmd_q & word_eff[idx_q[POS_W-1:0]];
			end
			S_RUN: begin
				end_all_q  <= row_last && (z_q == n_q - SIDE_W'(1));
				end_row_q  <= row_last;
				end_word_q <= word_last;
				idx_q      <= idx_q + CNT_W'(1);
				if (row_last) begin
					x_q   <= '0;
					z_q   <= z_q + SIDE_W'(1);
					cx2_q <= cx_init;
					cz2_q <= cz2_q + step2;
				end else begin
					x_q   <= x_q + SIDE_W'(1);
					cx2_q <= cx2_q + step2;
				end
			end
			S_WR: changed_q <= changed_q | (new_word != old_q);
			default: ;
		endcase
		if (v_s2 && hit_now) begin
			hit_q[pos_s2] <= 1'b1;
		end
	end

	a_pipe_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == S_RUN || state_q == S_DRAIN))
		else $error("quad pipeline busy outside the walk");

	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN && state_d != S_DRAIN) |-> (!v_s1 && !v_s2))
		else $error("drain left with quads in flight");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (idx_q < nn_q))
		else $error("walk index beyond quads in use");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result item raised outside done");

endmodule
